// ===== rtl/cpt_pkg.sv =====
package cpt_pkg;

    // Width of the slices of B that the partial-product multipliers consume per stage.
    localparam int MUL_CHUNK = 18;

    // Entries in the queue between the classifier and the evaluation pipeline (power of two).
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [2:0] {
        REG_A,
        REG_B,
        REG_AB,
        REG_C,
        REG_AC,
        REG_BC,
        REG_IN
    } t_region;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

// ===== rtl/cpt_if.sv =====
interface cpt_in_if #(
    parameter int COORD_WIDTH = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] vertex_a_x;
    logic signed [COORD_WIDTH-1:0] vertex_a_y;
    logic signed [COORD_WIDTH-1:0] vertex_a_z;
    logic signed [COORD_WIDTH-1:0] vertex_b_x;
    logic signed [COORD_WIDTH-1:0] vertex_b_y;
    logic signed [COORD_WIDTH-1:0] vertex_b_z;
    logic signed [COORD_WIDTH-1:0] vertex_c_x;
    logic signed [COORD_WIDTH-1:0] vertex_c_y;
    logic signed [COORD_WIDTH-1:0] vertex_c_z;
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    logic signed [COORD_WIDTH-1:0] point_z;

    modport source (
        output valid, vertex_a_x, vertex_a_y, vertex_a_z, vertex_b_x, vertex_b_y, vertex_b_z,
               vertex_c_x, vertex_c_y, vertex_c_z, point_x, point_y, point_z,
        input  ready
    );
    modport sink (
        input  valid, vertex_a_x, vertex_a_y, vertex_a_z, vertex_b_x, vertex_b_y, vertex_b_z,
               vertex_c_x, vertex_c_y, vertex_c_z, point_x, point_y, point_z,
        output ready
    );
endinterface

interface cpt_out_if #(
    parameter int COORD_WIDTH = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] nearest_x;
    logic signed [COORD_WIDTH-1:0] nearest_y;
    logic signed [COORD_WIDTH-1:0] nearest_z;

    modport source (output valid, nearest_x, nearest_y, nearest_z, input ready);
    modport sink (input valid, nearest_x, nearest_y, nearest_z, output ready);
endinterface

// ===== rtl/cpt_mul.sv =====
module cpt_mul
    import cpt_pkg::*;
#(
    parameter int WA = 17,
    parameter int WB = 17
) (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic signed [WA-1:0]    i_a,
    input  logic signed [WB-1:0]    i_b,
    output logic signed [WA+WB-1:0] o_p
);

    localparam int NC = (WB + MUL_CHUNK - 1) / MUL_CHUNK;
    localparam int BW = NC * MUL_CHUNK;
    localparam int PW = WA + MUL_CHUNK + 1;
    localparam int AW = WA + BW + 1;

    logic signed [WA-1:0] r_a   [NC];
    logic signed [BW-1:0] r_b   [NC];
    logic signed [AW-1:0] r_acc [NC];
    logic signed [BW-1:0] b_ext;

    assign b_ext = BW'(i_b);

    // One slice of B per stage; only the top slice carries the sign.
    for (genvar k = 0; k < NC; k++) begin : g_stage
        logic signed [WA-1:0] a_in;
        logic signed [BW-1:0] b_in;
        logic signed [AW-1:0] acc_in;
        logic signed [PW-1:0] ea;
        logic signed [PW-1:0] eb;
        logic signed [PW-1:0] prod;

        if (k == 0) begin : g_first
            assign a_in   = i_a;
            assign b_in   = b_ext;
            assign acc_in = '0;
        end else begin : g_next
            assign a_in   = r_a[k-1];
            assign b_in   = r_b[k-1];
            assign acc_in = r_acc[k-1];
        end

        if (k == NC - 1) begin : g_top
            assign eb = PW'($signed(b_in[k*MUL_CHUNK +: MUL_CHUNK]));
        end else begin : g_low
            assign eb = PW'({1'b0, b_in[k*MUL_CHUNK +: MUL_CHUNK]});
        end

        assign ea   = PW'(a_in);
        assign prod = ea * eb;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_a[k]   <= a_in;
                r_b[k]   <= b_in;
                r_acc[k] <= acc_in + (AW'(prod) <<< (k * MUL_CHUNK));
            end
        end
    end

    assign o_p = r_acc[NC-1][WA+WB-1:0];

endmodule

// ===== rtl/cpt_div.sv =====
module cpt_div #(
    parameter int UW = 93,
    parameter int QB = 17
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [UW-1:0] i_num,
    input  logic [UW-1:0] i_den,
    output logic [QB-1:0] o_quo,
    output logic          o_ovf
);

    localparam int XW = UW + QB + 1;

    logic [XW-1:0] r_rem [QB+1];
    logic [UW-1:0] r_den [QB+1];
    logic [QB-1:0] r_quo [QB+1];
    logic          r_ovf [QB+1];

    // The first stage flags quotients of 2^QB or more; the rest restore one bit each.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= XW'(i_num);
            r_den[0] <= i_den;
            r_quo[0] <= '0;
            r_ovf[0] <= XW'(i_num) >= (XW'(i_den) << QB);
        end
    end

    for (genvar s = 1; s <= QB; s++) begin : g_bit
        localparam int J = QB - s;
        logic [XW-1:0] sh;
        logic          ge;

        assign sh = XW'(r_den[s-1]) << J;
        assign ge = r_rem[s-1] >= sh;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s] <= ge ? r_rem[s-1] - sh : r_rem[s-1];
                r_den[s] <= r_den[s-1];
                r_quo[s] <= r_quo[s-1] | ({{(QB-1){1'b0}}, ge} << J);
                r_ovf[s] <= r_ovf[s-1];
            end
        end
    end

    assign o_quo = r_quo[QB];
    assign o_ovf = r_ovf[QB];

endmodule

// ===== rtl/cpt_fifo.sv =====
module cpt_fifo
    import cpt_pkg::*;
#(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output t_q_stat      o_stat
);

    localparam int AW = $clog2(QUEUE_DEPTH);

    logic [W-1:0] r_mem [QUEUE_DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [AW:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(i_push) - (AW+1)'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_data       = r_mem[r_rd];
    assign o_stat.full  = r_cnt == (AW+1)'(QUEUE_DEPTH);
    assign o_stat.empty = r_cnt == '0;

endmodule

// ===== rtl/cpt_front.sv =====
module cpt_front
    import cpt_pkg::*;
#(
    parameter int CW = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    cpt_in_if.sink                      i_item,
    input  t_q_stat                     i_q_stat,
    output logic                        o_push,
    output logic signed [CW-1:0]        o_base [3],
    output logic signed [CW:0]          o_dir1 [3],
    output logic signed [CW:0]          o_dir2 [3],
    output logic signed [4*CW+8:0]      o_n1,
    output logic signed [4*CW+8:0]      o_n2,
    output logic signed [4*CW+10:0]     o_den
);

    localparam int DW  = CW + 1;
    localparam int PRW = 2 * DW;
    localparam int PW  = PRW + 2;
    localparam int NVW = 2 * PW + 1;
    localparam int DNW = 2 * PW + 3;
    localparam int NCM = (PW + MUL_CHUNK - 1) / MUL_CHUNK;
    localparam int LF  = NCM + 6;
    localparam int LV  = LF - 2;

    // Cross-term products: vc = d1*d4 - d3*d2, vb = d5*d2 - d1*d6, va = d3*d6 - d5*d4.
    localparam int MA [6] = '{0, 2, 4, 0, 2, 4};
    localparam int MB [6] = '{3, 1, 1, 5, 5, 3};

    logic [LF-1:0] r_fv;
    logic          advance;

    logic signed [CW-1:0]  in_a [3];
    logic signed [CW-1:0]  in_b [3];
    logic signed [CW-1:0]  in_c [3];
    logic signed [CW-1:0]  in_p [3];

    logic signed [CW-1:0]  r_pa [3];
    logic signed [CW-1:0]  r_pb [3];
    logic signed [CW-1:0]  r_pc [3];
    logic signed [CW-1:0]  r_pp [3];

    logic signed [CW-1:0]  r_a  [1:LV][3];
    logic signed [CW-1:0]  r_b  [1:LV][3];
    logic signed [CW-1:0]  r_c  [1:LV][3];
    logic signed [DW-1:0]  r_ab [1:LV][3];
    logic signed [DW-1:0]  r_ac [1:LV][3];
    logic signed [DW-1:0]  r_bc [1:LV][3];
    logic signed [DW-1:0]  r_ap [3];
    logic signed [DW-1:0]  r_bp [3];
    logic signed [DW-1:0]  r_cp [3];
    logic signed [PRW-1:0] r_prod [6][3];
    logic signed [PW-1:0]  r_d  [3:LV][6];
    logic signed [2*PW-1:0] m_p [6];
    logic signed [NVW-1:0] r_va;
    logic signed [NVW-1:0] r_vb;
    logic signed [NVW-1:0] r_vc;

    logic signed [PW-1:0]  d1, d2, d3, d4, d5, d6;
    t_region               n_region;
    logic signed [CW-1:0]  n_base [3];
    logic signed [DW-1:0]  n_dir1 [3];
    logic signed [DW-1:0]  n_dir2 [3];
    logic signed [NVW-1:0] n_n1;
    logic signed [NVW-1:0] n_n2;
    logic signed [DNW-1:0] n_den;

    logic signed [CW-1:0]  r_base [3];
    logic signed [DW-1:0]  r_dir1 [3];
    logic signed [DW-1:0]  r_dir2 [3];
    logic signed [NVW-1:0] r_n1;
    logic signed [NVW-1:0] r_n2;
    logic signed [DNW-1:0] r_den;

    assign in_a[0] = i_item.vertex_a_x;
    assign in_a[1] = i_item.vertex_a_y;
    assign in_a[2] = i_item.vertex_a_z;
    assign in_b[0] = i_item.vertex_b_x;
    assign in_b[1] = i_item.vertex_b_y;
    assign in_b[2] = i_item.vertex_b_z;
    assign in_c[0] = i_item.vertex_c_x;
    assign in_c[1] = i_item.vertex_c_y;
    assign in_c[2] = i_item.vertex_c_z;
    assign in_p[0] = i_item.point_x;
    assign in_p[1] = i_item.point_y;
    assign in_p[2] = i_item.point_z;

    // The whole front moves as one; it halts only when its last stage cannot enter the queue.
    assign advance      = ~r_fv[LF-1] | ~i_q_stat.full;
    assign o_push       = r_fv[LF-1] & ~i_q_stat.full;
    assign i_item.ready = advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= '0;
        end else if (advance) begin
            r_fv <= {r_fv[LF-2:0], i_item.valid};
        end
    end

    for (genvar g = 0; g < 6; g++) begin : g_cross
        cpt_mul #(
            .WA (PW),
            .WB (PW)
        ) u_mul (
            .i_clk (i_clk),
            .i_en  (advance),
            .i_a   (r_d[3][MA[g]]),
            .i_b   (r_d[3][MB[g]]),
            .o_p   (m_p[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            for (int k = 0; k < 3; k++) begin
                r_pa[k] <= in_a[k];
                r_pb[k] <= in_b[k];
                r_pc[k] <= in_c[k];
                r_pp[k] <= in_p[k];

                r_a[1][k]  <= r_pa[k];
                r_b[1][k]  <= r_pb[k];
                r_c[1][k]  <= r_pc[k];
                r_ab[1][k] <= DW'(r_pb[k]) - DW'(r_pa[k]);
                r_ac[1][k] <= DW'(r_pc[k]) - DW'(r_pa[k]);
                r_bc[1][k] <= DW'(r_pc[k]) - DW'(r_pb[k]);
                r_ap[k]    <= DW'(r_pp[k]) - DW'(r_pa[k]);
                r_bp[k]    <= DW'(r_pp[k]) - DW'(r_pb[k]);
                r_cp[k]    <= DW'(r_pp[k]) - DW'(r_pc[k]);

                r_prod[0][k] <= PRW'(r_ab[1][k]) * PRW'(r_ap[k]);
                r_prod[1][k] <= PRW'(r_ac[1][k]) * PRW'(r_ap[k]);
                r_prod[2][k] <= PRW'(r_ab[1][k]) * PRW'(r_bp[k]);
                r_prod[3][k] <= PRW'(r_ac[1][k]) * PRW'(r_bp[k]);
                r_prod[4][k] <= PRW'(r_ab[1][k]) * PRW'(r_cp[k]);
                r_prod[5][k] <= PRW'(r_ac[1][k]) * PRW'(r_cp[k]);

                for (int s = 2; s <= LV; s++) begin
                    r_a[s][k]  <= r_a[s-1][k];
                    r_b[s][k]  <= r_b[s-1][k];
                    r_c[s][k]  <= r_c[s-1][k];
                    r_ab[s][k] <= r_ab[s-1][k];
                    r_ac[s][k] <= r_ac[s-1][k];
                    r_bc[s][k] <= r_bc[s-1][k];
                end
            end

            for (int j = 0; j < 6; j++) begin
                r_d[3][j] <= PW'(r_prod[j][0]) + PW'(r_prod[j][1]) + PW'(r_prod[j][2]);
                for (int s = 4; s <= LV; s++) begin
                    r_d[s][j] <= r_d[s-1][j];
                end
            end

            r_vc <= NVW'(m_p[0]) - NVW'(m_p[1]);
            r_vb <= NVW'(m_p[2]) - NVW'(m_p[3]);
            r_va <= NVW'(m_p[4]) - NVW'(m_p[5]);

            for (int k = 0; k < 3; k++) begin
                r_base[k] <= n_base[k];
                r_dir1[k] <= n_dir1[k];
                r_dir2[k] <= n_dir2[k];
            end
            r_n1  <= n_n1;
            r_n2  <= n_n2;
            r_den <= n_den;
        end
    end

    assign d1 = r_d[LV][0];
    assign d2 = r_d[LV][1];
    assign d3 = r_d[LV][2];
    assign d4 = r_d[LV][3];
    assign d5 = r_d[LV][4];
    assign d6 = r_d[LV][5];

    // Region tests in priority order: vertices and edges first, interior last.
    always_comb begin
        if (d1 <= 0 && d2 <= 0) begin
            n_region = REG_A;
        end else if (d3 >= 0 && d4 <= d3) begin
            n_region = REG_B;
        end else if (r_vc <= 0 && d1 >= 0 && d3 <= 0) begin
            n_region = REG_AB;
        end else if (d6 >= 0 && d5 <= d6) begin
            n_region = REG_C;
        end else if (r_vb <= 0 && d2 >= 0 && d6 <= 0) begin
            n_region = REG_AC;
        end else if (r_va <= 0 && d4 >= d3 && d5 >= d6) begin
            n_region = REG_BC;
        end else begin
            n_region = REG_IN;
        end
    end

    // A zero denominator tells the evaluation side to return the base vertex as is.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_base[k] = r_a[LV][k];
            n_dir1[k] = r_ab[LV][k];
            n_dir2[k] = r_ac[LV][k];
        end
        n_n1  = '0;
        n_n2  = '0;
        n_den = '0;
        case (n_region)
            REG_A: begin
                n_den = '0;
            end
            REG_B: begin
                for (int k = 0; k < 3; k++) begin
                    n_base[k] = r_b[LV][k];
                end
            end
            REG_AB: begin
                n_n1  = NVW'(d1);
                n_den = DNW'(d1) - DNW'(d3);
            end
            REG_C: begin
                for (int k = 0; k < 3; k++) begin
                    n_base[k] = r_c[LV][k];
                end
            end
            REG_AC: begin
                for (int k = 0; k < 3; k++) begin
                    n_dir1[k] = r_ac[LV][k];
                end
                n_n1  = NVW'(d2);
                n_den = DNW'(d2) - DNW'(d6);
            end
            REG_BC: begin
                for (int k = 0; k < 3; k++) begin
                    n_base[k] = r_b[LV][k];
                    n_dir1[k] = r_bc[LV][k];
                end
                n_n1  = NVW'(d4) - NVW'(d3);
                n_den = DNW'(d4) - DNW'(d3) + DNW'(d5) - DNW'(d6);
            end
            REG_IN: begin
                n_n1  = r_vb;
                n_n2  = r_vc;
                n_den = DNW'(r_va) + DNW'(r_vb) + DNW'(r_vc);
            end
            default: begin
                n_den = '0;
            end
        endcase
    end

    assign o_base = r_base;
    assign o_dir1 = r_dir1;
    assign o_dir2 = r_dir2;
    assign o_n1   = r_n1;
    assign o_n2   = r_n2;
    assign o_den  = r_den;

endmodule

// ===== rtl/cpt_back.sv =====
module cpt_back
    import cpt_pkg::*;
#(
    parameter int CW = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_q_stat                     i_q_stat,
    output logic                        o_pop,
    input  logic signed [CW-1:0]        i_base [3],
    input  logic signed [CW:0]          i_dir1 [3],
    input  logic signed [CW:0]          i_dir2 [3],
    input  logic signed [4*CW+8:0]      i_n1,
    input  logic signed [4*CW+8:0]      i_n2,
    input  logic signed [4*CW+10:0]     i_den,
    cpt_out_if.source                   o_result
);

    localparam int DW  = CW + 1;
    localparam int PW  = 2 * DW + 2;
    localparam int NVW = 2 * PW + 1;
    localparam int DNW = 2 * PW + 3;
    localparam int MW  = DW + NVW;
    localparam int NMW = MW + 1;
    localparam int UW  = ((NMW > DNW) ? NMW : DNW) + 2;
    localparam int QB  = CW + 1;
    localparam int NCN = (NVW + MUL_CHUNK - 1) / MUL_CHUNK;
    localparam int LB  = NCN + QB + 4;

    localparam logic signed [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};

    logic [LB-1:0] r_bv;
    logic          advance;

    logic signed [MW-1:0]  m_p1 [3];
    logic signed [MW-1:0]  m_p2 [3];
    logic signed [CW-1:0]  r_mbase [NCN][3];
    logic signed [DNW-1:0] r_mden  [NCN];

    logic signed [NMW-1:0] r_num [3];
    logic signed [CW-1:0]  r_sbase [3];
    logic signed [DNW-1:0] r_sden;

    logic signed [UW-1:0]  sx_num [3];
    logic signed [UW-1:0]  sx_den;
    logic [UW-1:0]         abs_num [3];
    logic [UW-1:0]         abs_den;

    logic [UW-1:0]         r_unum [3];
    logic [UW-1:0]         r_uden;
    logic                  r_aneg [3];
    logic                  r_azero;
    logic signed [CW-1:0]  r_abase [3];

    logic signed [CW-1:0]  r_dbase [QB+1][3];
    logic                  r_dneg  [QB+1][3];
    logic                  r_dzero [QB+1];

    logic [QB-1:0]         quo [3];
    logic                  ovf [3];
    logic signed [QB:0]    mag [3];
    logic signed [QB:0]    sq  [3];
    logic signed [QB+1:0]  sum [3];
    logic signed [CW-1:0]  n_res [3];
    logic signed [CW-1:0]  r_res [3];

    // The output register is the last stage; the pipe moves whenever it is empty or taken.
    assign advance = ~r_bv[LB-1] | o_result.ready;
    assign o_pop   = advance & ~i_q_stat.empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bv <= '0;
        end else if (advance) begin
            r_bv <= {r_bv[LB-2:0], o_pop};
        end
    end

    for (genvar k = 0; k < 3; k++) begin : g_coord
        cpt_mul #(
            .WA (DW),
            .WB (NVW)
        ) u_mul1 (
            .i_clk (i_clk),
            .i_en  (advance),
            .i_a   (i_dir1[k]),
            .i_b   (i_n1),
            .o_p   (m_p1[k])
        );

        cpt_mul #(
            .WA (DW),
            .WB (NVW)
        ) u_mul2 (
            .i_clk (i_clk),
            .i_en  (advance),
            .i_a   (i_dir2[k]),
            .i_b   (i_n2),
            .o_p   (m_p2[k])
        );

        cpt_div #(
            .UW (UW),
            .QB (QB)
        ) u_div (
            .i_clk (i_clk),
            .i_en  (advance),
            .i_num (r_unum[k]),
            .i_den (r_uden),
            .o_quo (quo[k]),
            .o_ovf (ovf[k])
        );

        assign sx_num[k]  = UW'(r_num[k]);
        assign abs_num[k] = sx_num[k][UW-1] ? UW'(-sx_num[k]) : UW'(sx_num[k]);
    end

    assign sx_den  = UW'(r_sden);
    assign abs_den = sx_den[UW-1] ? UW'(-sx_den) : UW'(sx_den);

    always_ff @(posedge i_clk) begin
        if (advance) begin
            for (int k = 0; k < 3; k++) begin
                r_mbase[0][k] <= i_base[k];
                for (int s = 1; s < NCN; s++) begin
                    r_mbase[s][k] <= r_mbase[s-1][k];
                end

                r_num[k]   <= NMW'(m_p1[k]) + NMW'(m_p2[k]);
                r_sbase[k] <= r_mbase[NCN-1][k];

                // Rounding to nearest, ties away from zero: (2|n| + |d|) / (2|d|).
                r_unum[k]  <= (abs_num[k] << 1) + abs_den;
                r_aneg[k]  <= r_num[k][NMW-1] ^ r_sden[DNW-1];
                r_abase[k] <= r_sbase[k];

                r_dbase[0][k] <= r_abase[k];
                r_dneg[0][k]  <= r_aneg[k];
                for (int s = 1; s <= QB; s++) begin
                    r_dbase[s][k] <= r_dbase[s-1][k];
                    r_dneg[s][k]  <= r_dneg[s-1][k];
                end

                r_res[k] <= n_res[k];
            end

            r_mden[0] <= i_den;
            for (int s = 1; s < NCN; s++) begin
                r_mden[s] <= r_mden[s-1];
            end
            r_sden  <= r_mden[NCN-1];
            r_uden  <= abs_den << 1;
            r_azero <= r_sden == '0;

            r_dzero[0] <= r_azero;
            for (int s = 1; s <= QB; s++) begin
                r_dzero[s] <= r_dzero[s-1];
            end
        end
    end

    // A quotient flagged as too large always drives the sum past the coordinate range.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            mag[k] = {1'b0, quo[k]};
            sq[k]  = r_dneg[QB][k] ? -mag[k] : mag[k];
            sum[k] = (QB+2)'(r_dbase[QB][k]) + (QB+2)'(sq[k]);
            if (r_dzero[QB]) begin
                n_res[k] = r_dbase[QB][k];
            end else if (ovf[k]) begin
                n_res[k] = r_dneg[QB][k] ? C_MIN : C_MAX;
            end else if (sum[k] > (QB+2)'(C_MAX)) begin
                n_res[k] = C_MAX;
            end else if (sum[k] < (QB+2)'(C_MIN)) begin
                n_res[k] = C_MIN;
            end else begin
                n_res[k] = sum[k][CW-1:0];
            end
        end
    end

    assign o_result.valid     = r_bv[LB-1];
    assign o_result.nearest_x = r_res[0];
    assign o_result.nearest_y = r_res[1];
    assign o_result.nearest_z = r_res[2];

endmodule

// ===== rtl/closest_point_on_triangle.sv =====
// Closest point on a 3-D triangle, signed fixed point.
// i_item carries vertices A, B, C and a query point P; o_result returns the point of
// the triangle nearest to P, each coordinate rounded to nearest and saturated.
// Both channels are valid/ready; a transfer happens when both are high.
// Throughput is one item per clock while the receiver keeps ready high. The depth
// of the pipeline grows with COORD_WIDTH and with NCM and NCN, the slice counts of
// the partial-product multipliers. The longest stretch is the per-coordinate
// divider, one quotient bit per stage.
// A classifier pipeline computes dot products and the Voronoi region, then writes a
// four-entry queue; an evaluation pipeline forms the weighted offsets, divides and
// saturates into the output register.
// When the receiver holds ready low, the evaluation pipeline freezes and the queue
// fills; once it is full the classifier freezes and i_item.ready drops.
// Reset clears all valid bits and the queue; no transfer is pending after it.
module closest_point_on_triangle
    import cpt_pkg::*;
#(
    parameter int COORD_WIDTH = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cpt_in_if.sink     i_item,
    cpt_out_if.source  o_result
);

    localparam int CW  = COORD_WIDTH;
    localparam int DW  = CW + 1;
    localparam int PW  = 2 * DW + 2;
    localparam int NVW = 2 * PW + 1;
    localparam int DNW = 2 * PW + 3;
    localparam int QW  = 3 * CW + 6 * DW + 2 * NVW + DNW;

    logic                  q_push;
    logic                  q_pop;
    t_q_stat               q_stat;
    logic [QW-1:0]         q_wdata;
    logic [QW-1:0]         q_rdata;

    logic signed [CW-1:0]  f_base [3];
    logic signed [DW-1:0]  f_dir1 [3];
    logic signed [DW-1:0]  f_dir2 [3];
    logic signed [NVW-1:0] f_n1;
    logic signed [NVW-1:0] f_n2;
    logic signed [DNW-1:0] f_den;

    logic signed [CW-1:0]  b_base [3];
    logic signed [DW-1:0]  b_dir1 [3];
    logic signed [DW-1:0]  b_dir2 [3];
    logic signed [NVW-1:0] b_n1;
    logic signed [NVW-1:0] b_n2;
    logic signed [DNW-1:0] b_den;

    cpt_front #(
        .CW (CW)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_q_stat (q_stat),
        .o_push   (q_push),
        .o_base   (f_base),
        .o_dir1   (f_dir1),
        .o_dir2   (f_dir2),
        .o_n1     (f_n1),
        .o_n2     (f_n2),
        .o_den    (f_den)
    );

    assign q_wdata = {f_base[0], f_base[1], f_base[2],
                      f_dir1[0], f_dir1[1], f_dir1[2],
                      f_dir2[0], f_dir2[1], f_dir2[2],
                      f_n1, f_n2, f_den};

    cpt_fifo #(
        .W (QW)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .i_pop   (q_pop),
        .o_data  (q_rdata),
        .o_stat  (q_stat)
    );

    assign {b_base[0], b_base[1], b_base[2],
            b_dir1[0], b_dir1[1], b_dir1[2],
            b_dir2[0], b_dir2[1], b_dir2[2],
            b_n1, b_n2, b_den} = q_rdata;

    cpt_back #(
        .CW (CW)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_stat (q_stat),
        .o_pop    (q_pop),
        .i_base   (b_base),
        .i_dir1   (b_dir1),
        .i_dir2   (b_dir2),
        .i_n1     (b_n1),
        .i_n2     (b_n2),
        .i_den    (b_den),
        .o_result (o_result)
    );

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_stat.full)
        else $error("queue written while full");

    a_pop_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_stat.empty)
        else $error("queue read while empty");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_item.ready |-> q_stat.full)
        else $error("input stalled while the queue has room");

    a_push_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_push && !q_pop) |=> !q_stat.empty)
        else $error("queue empty right after a transfer into it");

endmodule

// ===== bench/closest_point_on_triangle_test.sv =====
module closest_point_on_triangle_test;
    import cpt_pkg::*;

    localparam int CW = 16;
    localparam int N_RANDOM = 1850;

    typedef logic signed [CW-1:0] t_coord;
    typedef logic signed [95:0] t_big;

    typedef struct {
        t_coord x, y, z;
    } t_point;

    typedef struct {
        t_point a, b, c, p;
    } t_query;

    function automatic t_big dot3(t_big ux, t_big uy, t_big uz,
                                  t_big vx, t_big vy, t_big vz);
        return ux * vx + uy * vy + uz * vz;
    endfunction

    // Quotient rounded to nearest, ties away from zero.
    function automatic t_big round_quot(t_big n, t_big d);
        t_big an;
        t_big ad;
        t_big q;
        an = (n < 0) ? -n : n;
        ad = (d < 0) ? -d : d;
        q = (2 * an + ad) / (2 * ad);
        return ((n < 0) != (d < 0)) ? -q : q;
    endfunction

    function automatic t_coord clamp_coord(t_big v);
        if (v > 32767) return 16'sh7fff;
        if (v < -32768) return -16'sh8000;
        return t_coord'(v);
    endfunction

    // Nearest point: base + (dir1*n1 + dir2*n2)/den, or base alone when den is zero.
    function automatic t_point nearest_point(t_query q);
        t_big a[3], b[3], c[3], p[3], ab[3], ac[3], ap[3], bp[3], cp[3];
        t_big base[3], e1[3], e2[3];
        t_big d1, d2, d3, d4, d5, d6, va, vb, vc, n1, n2, den, r[3];
        t_region reg_sel;
        t_point res;
        a = '{q.a.x, q.a.y, q.a.z};
        b = '{q.b.x, q.b.y, q.b.z};
        c = '{q.c.x, q.c.y, q.c.z};
        p = '{q.p.x, q.p.y, q.p.z};
        for (int k = 0; k < 3; k++) begin
            ab[k] = b[k] - a[k];
            ac[k] = c[k] - a[k];
            ap[k] = p[k] - a[k];
            bp[k] = p[k] - b[k];
            cp[k] = p[k] - c[k];
        end
        d1 = dot3(ab[0], ab[1], ab[2], ap[0], ap[1], ap[2]);
        d2 = dot3(ac[0], ac[1], ac[2], ap[0], ap[1], ap[2]);
        d3 = dot3(ab[0], ab[1], ab[2], bp[0], bp[1], bp[2]);
        d4 = dot3(ac[0], ac[1], ac[2], bp[0], bp[1], bp[2]);
        d5 = dot3(ab[0], ab[1], ab[2], cp[0], cp[1], cp[2]);
        d6 = dot3(ac[0], ac[1], ac[2], cp[0], cp[1], cp[2]);
        vc = d1 * d4 - d3 * d2;
        vb = d5 * d2 - d1 * d6;
        va = d3 * d6 - d5 * d4;
        if (d1 <= 0 && d2 <= 0) reg_sel = REG_A;
        else if (d3 >= 0 && d4 <= d3) reg_sel = REG_B;
        else if (vc <= 0 && d1 >= 0 && d3 <= 0) reg_sel = REG_AB;
        else if (d6 >= 0 && d5 <= d6) reg_sel = REG_C;
        else if (vb <= 0 && d2 >= 0 && d6 <= 0) reg_sel = REG_AC;
        else if (va <= 0 && d4 >= d3 && d5 >= d6) reg_sel = REG_BC;
        else reg_sel = REG_IN;
        base = a;
        e1 = ab;
        e2 = ac;
        n1 = 0;
        n2 = 0;
        den = 0;
        case (reg_sel)
            REG_B: base = b;
            REG_C: base = c;
            REG_AB: begin
                n1 = d1;
                den = d1 - d3;
            end
            REG_AC: begin
                e1 = ac;
                n1 = d2;
                den = d2 - d6;
            end
            REG_BC: begin
                base = b;
                for (int k = 0; k < 3; k++) e1[k] = c[k] - b[k];
                n1 = d4 - d3;
                den = n1 + d5 - d6;
            end
            REG_IN: begin
                n1 = vb;
                n2 = vc;
                den = va + vb + vc;
            end
            default: ;
        endcase
        for (int k = 0; k < 3; k++) begin
            r[k] = base[k];
            if (den != 0) r[k] = r[k] + round_quot(e1[k] * n1 + e2[k] * n2, den);
        end
        res.x = clamp_coord(r[0]);
        res.y = clamp_coord(r[1]);
        res.z = clamp_coord(r[2]);
        return res;
    endfunction

    class nearest_scoreboard;
        t_point pending[$];
        int errors;

        function void note_query(t_query q);
            pending.push_back(nearest_point(q));
        endfunction

        function void check_result(t_point got);
            t_point want;
            if (pending.size() == 0) begin
                report_mismatch("result with no query outstanding");
                return;
            end
            want = pending.pop_front();
            if (got.x !== want.x)
                report_mismatch($sformatf("nearest_x got %0d want %0d", got.x, want.x));
            if (got.y !== want.y)
                report_mismatch($sformatf("nearest_y got %0d want %0d", got.y, want.y));
            if (got.z !== want.z)
                report_mismatch($sformatf("nearest_z got %0d want %0d", got.z, want.z));
        endfunction

        function void report_mismatch(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    cpt_in_if #(.COORD_WIDTH(CW)) item_ch ();
    cpt_out_if #(.COORD_WIDTH(CW)) result_ch ();
    nearest_scoreboard sb = new();
    bit sending_done = 1'b0;

    closest_point_on_triangle #(.COORD_WIDTH(CW)) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_ch.sink),
        .o_result(result_ch.source)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        item_ch.valid = 1'b0;
        {item_ch.vertex_a_x, item_ch.vertex_a_y, item_ch.vertex_a_z} = '0;
        {item_ch.vertex_b_x, item_ch.vertex_b_y, item_ch.vertex_b_z} = '0;
        {item_ch.vertex_c_x, item_ch.vertex_c_y, item_ch.vertex_c_z} = '0;
        {item_ch.point_x, item_ch.point_y, item_ch.point_z} = '0;
        result_ch.ready = 1'b0;
    end

    function automatic t_coord rand_coord(int mode);
        case (mode)
            0: return t_coord'($urandom);
            1: return t_coord'($urandom_range(0, 64)) - 16'sd32;
            2: return ($urandom_range(0, 1)) ? 16'sh7fff : -16'sh8000;
            default: return t_coord'($urandom_range(0, 4096)) - 16'sd2048;
        endcase
    endfunction

    function automatic t_point rand_point(int mode);
        t_point r;
        r.x = rand_coord(mode);
        r.y = rand_coord(mode);
        r.z = rand_coord(mode);
        return r;
    endfunction

    function automatic t_point mk(int x, int y, int z);
        t_point r;
        r.x = t_coord'(x);
        r.y = t_coord'(y);
        r.z = t_coord'(z);
        return r;
    endfunction

    // Valid drops only while idling, so consecutive items never drive it twice at one edge.
    task automatic send_query(t_query q);
        int idle;
        idle = $urandom_range(0, 10);
        if (idle > 0) begin
            item_ch.valid <= 1'b0;
            repeat (idle) @(posedge i_clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.vertex_a_x <= q.a.x;
        item_ch.vertex_a_y <= q.a.y;
        item_ch.vertex_a_z <= q.a.z;
        item_ch.vertex_b_x <= q.b.x;
        item_ch.vertex_b_y <= q.b.y;
        item_ch.vertex_b_z <= q.b.z;
        item_ch.vertex_c_x <= q.c.x;
        item_ch.vertex_c_y <= q.c.y;
        item_ch.vertex_c_z <= q.c.z;
        item_ch.point_x <= q.p.x;
        item_ch.point_y <= q.p.y;
        item_ch.point_z <= q.p.z;
        do @(posedge i_clk); while (item_ch.ready !== 1'b1);
        sb.note_query(q);
    endtask

    task automatic send_burst(t_query q);
        // Back-to-back transfer with no idle cycle.
        item_ch.valid <= 1'b1;
        {item_ch.vertex_a_x, item_ch.vertex_a_y, item_ch.vertex_a_z} <= {q.a.x, q.a.y, q.a.z};
        {item_ch.vertex_b_x, item_ch.vertex_b_y, item_ch.vertex_b_z} <= {q.b.x, q.b.y, q.b.z};
        {item_ch.vertex_c_x, item_ch.vertex_c_y, item_ch.vertex_c_z} <= {q.c.x, q.c.y, q.c.z};
        {item_ch.point_x, item_ch.point_y, item_ch.point_z} <= {q.p.x, q.p.y, q.p.z};
        do @(posedge i_clk); while (item_ch.ready !== 1'b1);
        sb.note_query(q);
    endtask

    // Receiver: random stalls per result, with quiet stretches of none.
    initial begin
        int stall;
        int calm;
        t_point got;
        calm = 0;
        @(posedge i_clk);
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (calm > 0) begin
                calm--;
                stall = 0;
            end else begin
                stall = $urandom_range(0, 10);
                if ($urandom_range(0, 30) == 0) calm = 60;
            end
            if (stall > 0) begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            result_ch.ready <= 1'b1;
            do @(posedge i_clk); while (result_ch.valid !== 1'b1);
            got.x = result_ch.nearest_x;
            got.y = result_ch.nearest_y;
            got.z = result_ch.nearest_z;
            sb.check_result(got);
        end
    end

    initial begin
        t_query q;
        t_query directed[$];
        int mode;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Triangle (0,0,0) (256,0,0) (0,256,0) with P in each Voronoi region.
        q.a = mk(0, 0, 0); q.b = mk(256, 0, 0); q.c = mk(0, 256, 0);
        q.p = mk(-100, -100, 50); directed.push_back(q);
        q.p = mk(400, -10, 0); directed.push_back(q);
        q.p = mk(100, -50, 9); directed.push_back(q);
        q.p = mk(-10, 400, 0); directed.push_back(q);
        q.p = mk(-50, 100, -9); directed.push_back(q);
        q.p = mk(200, 200, 30); directed.push_back(q);
        q.p = mk(50, 60, 100); directed.push_back(q);
        q.p = mk(128, 128, 0); directed.push_back(q);
        // Degenerate: all vertices equal, collinear, zero-length edges.
        q.a = mk(10, 10, 10); q.b = q.a; q.c = q.a; q.p = mk(500, -3, 7);
        directed.push_back(q);
        q.a = mk(0, 0, 0); q.b = mk(100, 100, 100); q.c = mk(200, 200, 200);
        q.p = mk(150, 150, 140); directed.push_back(q);
        q.b = q.a; q.c = mk(0, 300, 0); q.p = mk(5, 100, 3); directed.push_back(q);
        q.a = mk(0, 0, 0); q.b = mk(300, 0, 0); q.c = q.b; q.p = mk(100, 50, 0);
        directed.push_back(q);
        // Coordinates at the ends of the signed range, then a small triangle about the origin.
        q.a = mk(-32768, -32768, -32768); q.b = mk(32767, 32767, 32767);
        q.c = mk(32767, -32768, 0); q.p = mk(32767, 0, -32768); directed.push_back(q);
        q.a = mk(32767, 32767, 32767); q.b = mk(-32768, 32767, -32768);
        q.c = mk(-32768, -32768, 32767); q.p = mk(-32768, -32768, -32768);
        directed.push_back(q);
        q.a = mk(-32768, 0, 0); q.b = mk(32767, 0, 0); q.c = mk(0, 32767, -32768);
        q.p = mk(1, 2, 3); directed.push_back(q);
        q.a = mk(-1, -1, -1); q.b = mk(1, 1, 1); q.c = mk(1, -1, 0);
        q.p = mk(0, 0, 0); directed.push_back(q);
        foreach (directed[i]) send_query(directed[i]);

        for (int n = 0; n < N_RANDOM; n++) begin
            mode = $urandom_range(0, 9);
            if (mode > 3) mode = 3;
            q.a = rand_point(mode);
            q.b = rand_point(mode);
            q.c = rand_point(mode);
            q.p = rand_point($urandom_range(0, 3));
            if (n == N_RANDOM / 2) begin
                // Let the pipeline drain completely before going on.
                item_ch.valid <= 1'b0;
                while (sb.pending.size() != 0) @(posedge i_clk);
            end
            if (n % 200 < 20) begin
                send_burst(q);
            end else begin
                send_query(q);
            end
        end
        item_ch.valid <= 1'b0;
        sending_done = 1'b1;
    end

    initial begin
        wait (sending_done);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (sb.errors == 0) $display("CHECK OK");
        else $display("CHECK FAILED");
        $finish;
    end

    initial begin
        #400000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
